// ----- hdl/rlft_pkg.sv -----
`default_nettype none
package rlft_pkg;

	localparam int unsigned QUEUE_DEPTH = 1024;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned ENTRY_W     = VAL_W + CNT_W;
	localparam int unsigned SUM_W       = 64;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_TAKE = 1'b1;

	typedef struct packed {
		logic clear;
		logic en;
	} mac_ctl_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/rlft_ram.sv -----
`default_nettype none
module rlft_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/rlft_mac.sv -----
`default_nettype none
module rlft_mac
	import rlft_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mac_ctl_t         ctl,
	input  wire logic [VAL_W-1:0] val,
	input  wire logic [CNT_W-1:0] take,
	output      logic [SUM_W-1:0] acc,
	output      logic             busy
);

	logic             v_s1;
	logic [SUM_W-1:0] prod_s1;
	logic [SUM_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.en;
			if (ctl.clear)
				acc_q <= '0;
			else if (v_s1)
				acc_q <= acc_q + prod_s1;
		end
	end

	// product of one run, registered before the accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= SUM_W'(val) * SUM_W'(take);
	end

	assign acc  = acc_q;
	assign busy = v_s1;

endmodule
`default_nettype wire

// ----- hdl/run_length_fifo_weighted_take.sv -----
// push: result goes through S_DONE into the output register on m_tvalid
// take: S_CALC walks the head runs touched (one run per cycle through the run memory
// read port and the multiply-accumulate unit); a zero or empty take skips S_CALC
// one item in flight; a finished result waits in the output register
// reset: pointers, occupancy and control cleared; run memory contents not cleared
`default_nettype none
module run_length_fifo_weighted_take
	import rlft_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [63:0] s_tdata,  // run_value, amount
	input  wire logic        s_tuser,  // func
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [63:0] m_tdata,  // taken_sum
	output      logic [1:0]  m_tuser   // shortfall, overflow
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_FLUSH,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;
	logic [CNT_W-1:0] left_q;
	logic             is_take_q;
	logic             over_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic             out_short_q;
	logic             out_over_q;

	logic [VAL_W-1:0] in_value;
	logic [CNT_W-1:0] in_amount;
	logic             accept;
	logic             take_start;
	logic             push_ok;

	logic [VAL_W-1:0] rd_val;
	logic [CNT_W-1:0] rd_cnt;
	logic [CNT_W-1:0] take_n;
	logic [CNT_W-1:0] left_n;
	logic             consumed;
	logic [OCC_W-1:0] occ_n;
	logic             cont;
	logic             out_free;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	mac_ctl_t         mac_ctl;
	logic [SUM_W-1:0] mac_acc;
	logic             mac_busy;

	assign in_value  = s_tdata[31:0];
	assign in_amount = s_tdata[63:32];
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign push_ok   = (in_amount != '0) && (occ_q != OCC_W'(QUEUE_DEPTH));
	assign take_start = accept && (s_tuser == FUNC_TAKE) && (in_amount != '0)
		&& (occ_q != '0);

	assign rd_cnt   = ram_rdata[ENTRY_W-1:VAL_W];
	assign rd_val   = ram_rdata[VAL_W-1:0];
	assign take_n   = (rd_cnt < left_q) ? rd_cnt : left_q;
	assign left_n   = left_q - take_n;
	assign consumed = (rd_cnt == take_n);
	assign occ_n    = consumed ? occ_q - OCC_W'(1) : occ_q;
	assign cont     = (left_n != '0) && (occ_n != '0);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {in_amount, in_value};
		ram_re    = 1'b0;
		ram_raddr = head_q;
		if (state_q == S_IDLE) begin
			ram_we = accept && (s_tuser == FUNC_PUSH) && push_ok;
			ram_re = take_start;
		end else if (state_q == S_CALC) begin
			// partly consumed head run keeps its remainder
			ram_we    = !consumed;
			ram_waddr = head_q;
			ram_wdata = {rd_cnt - take_n, rd_val};
			ram_re    = cont;
			ram_raddr = ptr_inc(head_q);
		end
	end

	assign mac_ctl.clear = accept && (s_tuser == FUNC_TAKE);
	assign mac_ctl.en    = (state_q == S_CALC);

	rlft_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rlft_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.val    (rd_val),
		.take   (take_n),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			left_q      <= '0;
			is_take_q   <= 1'b0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
			out_short_q <= 1'b0;
			out_over_q  <= 1'b0;
		end else begin
			if (m_tready && (state_q != S_DONE))
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						left_q    <= in_amount;
						is_take_q <= (s_tuser == FUNC_TAKE);
						over_q    <= 1'b0;
						if (s_tuser == FUNC_PUSH) begin
							if (push_ok) begin
								tail_q <= ptr_inc(tail_q);
								occ_q  <= occ_q + OCC_W'(1);
							end else if (in_amount != '0) begin
								over_q <= 1'b1;
							end
							state_q <= S_DONE;
						end else if (take_start) begin
							state_q <= S_CALC;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_CALC: begin
					left_q <= left_n;
					occ_q  <= occ_n;
					if (consumed)
						head_q <= ptr_inc(head_q);
					if (!cont)
						state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (!mac_busy)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_sum_q   <= is_take_q ? mac_acc : '0;
						out_short_q <= is_take_q && (left_q != '0);
						out_over_q  <= over_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sum_q;
	assign m_tuser  = {out_over_q, out_short_q};

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == tail_q))
		else $error("empty store with pointers apart");

	a_overflow_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
		else $error("overflow result carries sum or shortfall");

	a_calc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) |-> (occ_q != '0 && left_q != '0))
		else $error("run walk with nothing to take");

endmodule
`default_nettype wire

// ----- sim/run_length_fifo_weighted_take_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module run_length_fifo_weighted_take_test
	import rlft_pkg::*;
;

	typedef struct packed {
		logic [63:0] sum;
		logic        shortfall;
		logic        overflow;
	} tally_t;

	typedef struct packed {
		logic        func;
		logic [31:0] value;
		logic [31:0] amount;
		logic        typed;
		tally_t      want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	// shadow copy of the run store
	logic [31:0]      shadow_val [QUEUE_DEPTH];
	logic [31:0]      shadow_cnt [QUEUE_DEPTH];
	logic [PTR_W-1:0] shadow_head;
	logic [PTR_W-1:0] shadow_tail;
	logic [OCC_W-1:0] shadow_occ;

	tally_t pending_tallies [$];
	tally_t oldest_tally;
	int     mismatches = 0;
	int     overflows_seen = 0;
	bit     calm = 1'b0;

	step_t script [0:19] = '{
		'{FUNC_TAKE, 32'd0, 32'd0, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd5, 1'b1, '{64'd0, 1'b1, 1'b0}},
		'{FUNC_PUSH, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_PUSH, 32'd123, 32'd0, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'hFFFFFFFF, 1'b1, '{64'hFFFFFFFE00000001, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd1, 1'b1, '{64'd0, 1'b1, 1'b0}},
		'{FUNC_PUSH, 32'd7, 32'd3, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_PUSH, 32'd100, 32'd10, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd2, 1'b1, '{64'd14, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd0, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd5, 1'b1, '{64'd407, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd20, 1'b1, '{64'd600, 1'b1, 1'b0}},
		'{FUNC_PUSH, 32'd0, 32'd1, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_PUSH, 32'hFFFFFFFF, 32'd1, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_PUSH, 32'h80000000, 32'hFFFFFFFF, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_PUSH, 32'd1, 32'h80000000, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_PUSH, 32'h5A5A5A5A, 32'd2, 1'b1, '{64'd0, 1'b0, 1'b0}},
		'{FUNC_TAKE, 32'd0, 32'd3, 1'b0, '0},
		'{FUNC_TAKE, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0},
		'{FUNC_TAKE, 32'd0, 32'hFFFFFFFF, 1'b0, '0}
	};

	run_length_fifo_weighted_take u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic tally_t tally_item(input logic func, input logic [31:0] value,
			input logic [31:0] amount);
		tally_t      t;
		logic [31:0] left;
		logic [31:0] cnt;
		logic [31:0] part;
		t = '0;
		if (func == FUNC_PUSH) begin
			if (amount != 32'd0) begin
				if (shadow_occ >= OCC_W'(QUEUE_DEPTH)) begin
					t.overflow = 1'b1;
				end else begin
					shadow_val[shadow_tail] = value;
					shadow_cnt[shadow_tail] = amount;
					shadow_tail = (shadow_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : shadow_tail + 1'b1;
					shadow_occ = shadow_occ + 1'b1;
				end
			end
		end else begin
			left = amount;
			while (left != 32'd0 && shadow_occ != '0) begin
				cnt  = shadow_cnt[shadow_head];
				part = (cnt < left) ? cnt : left;
				t.sum = t.sum + {32'd0, shadow_val[shadow_head]} * {32'd0, part};
				left = left - part;
				if (cnt > part) begin
					shadow_cnt[shadow_head] = cnt - part;
				end else begin
					shadow_head = (shadow_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : shadow_head + 1'b1;
					shadow_occ = shadow_occ - 1'b1;
				end
			end
			t.shortfall = (left != 32'd0);
		end
		return t;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic send_item(input logic func, input logic [31:0] value, input logic [31:0] amount,
			input logic typed, input tally_t want);
		tally_t predicted;
		while (!calm && $urandom_range(0, 99) < 31) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= 1'($urandom);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {amount, value};
		s_tuser  <= func;
		do @(posedge clk); while (s_tready !== 1'b1);
		predicted = tally_item(func, value, amount);
		if (predicted.overflow)
			overflows_seen++;
		if (typed)
			predicted = want;
		pending_tallies = {pending_tallies, predicted};
	endtask

	task automatic sender_rest;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value;
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_run_length;
		case ($urandom_range(0, 19))
			0:       return 32'd0;
			1:       return 32'hFFFFFFFF;
			2, 3:    return $urandom;
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [31:0] pick_take_amount;
		case ($urandom_range(0, 19))
			0:       return 32'd0;
			1:       return 32'hFFFFFFFF;
			2:       return $urandom;
			3, 4, 5: return $urandom_range(1, 40);
			default: return $urandom_range(1, 10);
		endcase
	endfunction

	// sink side: ready toggling and result checks
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 31);

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_tallies.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata, '0);
			end else begin
				oldest_tally = pending_tallies[0];
				pending_tallies.delete(0);
				if (m_tdata !== oldest_tally.sum)
					report_mismatch("taken_sum", m_tdata, oldest_tally.sum);
				if (m_tuser[0] !== oldest_tally.shortfall)
					report_mismatch("shortfall", 64'(m_tuser[0]), 64'(oldest_tally.shortfall));
				if (m_tuser[1] !== oldest_tally.overflow)
					report_mismatch("overflow", 64'(m_tuser[1]), 64'(oldest_tally.overflow));
			end
		end
	end

	initial begin
		int fill_items;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = FUNC_PUSH;
		m_tready    = 1'b0;
		shadow_head = '0;
		shadow_tail = '0;
		shadow_occ  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_item(script[i].func, script[i].value, script[i].amount, script[i].typed,
				script[i].want);

		// mixed traffic through the run store
		repeat (300) begin
			if ($urandom_range(0, 99) < 55)
				send_item(FUNC_PUSH, pick_value(), pick_run_length(), 1'b0, '0);
			else
				send_item(FUNC_TAKE, 32'($urandom), pick_take_amount(), 1'b0, '0);
		end

		// hold off until the block has drained its results
		sender_rest();
		while (pending_tallies.size() != 0)
			@(posedge clk);

		// fill until the store is full and pushes get dropped
		fill_items = 0;
		while (overflows_seen < 30 && fill_items < 3000) begin
			calm = (fill_items < 300);
			if ($urandom_range(0, 99) < 92)
				send_item(FUNC_PUSH, pick_value(), pick_run_length(), 1'b0, '0);
			else
				send_item(FUNC_TAKE, 32'($urandom), $urandom_range(1, 2), 1'b0, '0);
			fill_items++;
		end
		calm = 1'b0;

		// drain with long takes
		repeat (200) begin
			if ($urandom_range(0, 99) < 25)
				send_item(FUNC_PUSH, pick_value(), pick_run_length(), 1'b0, '0);
			else if ($urandom_range(0, 1) == 0)
				send_item(FUNC_TAKE, 32'($urandom), $urandom, 1'b0, '0);
			else
				send_item(FUNC_TAKE, 32'($urandom), pick_take_amount(), 1'b0, '0);
		end

		sender_rest();
		while (pending_tallies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
